>>> rtl/core/adrc_pkg.sv
// Shared types, constants and helpers for the ADRC observer step.
// Holds the microcode word layout used by the sequencer and datapath, and the field types used by the multiplier.
// No dependencies.
package adrc_pkg;

  localparam int VAL_W = 48;
  localparam int DT_W = 24;
  localparam int SUM_W = 51;
  localparam int CFG_IDX_W = 3;
  localparam int UC_PC_W = 6;

  localparam logic [DT_W-1:0] DEFAULT_DT = 24'd16777;
  localparam logic [VAL_W-1:0] B0_FLOOR = 48'd66;
  localparam logic signed [VAL_W-1:0] GAIN_RESET = 48'sd65536;

  localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BETA1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BETA2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BETA3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KZ = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 3'd7;

  typedef enum logic [3:0] {
    A_NOP, A_ERR, A_SEED, A_D, A_N1, A_N2A, A_N2B, A_N3,
    A_Z1, A_Z2, A_Z3, A_T1, A_T2, A_T3, A_CLAMP
  } alu_op_t;

  typedef enum logic [3:0] {
    MS_NONE, MS_B1D, MS_B2D, MS_B0P, MS_B3D, MS_DT1, MS_DT2, MS_DT3,
    MS_KPZ1, MS_KDZ2, MS_KZZ3
  } msel_t;

  typedef enum logic [2:0] {PP_NONE, PP_LL, PP_HL, PP_LH, PP_HH} pp_t;

  typedef enum logic [1:0] {FIN_NONE, FIN_Q16, FIN_Q24} fin_t;

  typedef enum logic {J_NONE, J_SEEDED} jmp_t;

  typedef struct packed {
    alu_op_t alu;
    msel_t msel;
    pp_t pp;
    fin_t fin;
    jmp_t jmp;
    logic [UC_PC_W-1:0] target;
    logic last;
  } uc_word_t;

  localparam uc_word_t UC_NOP = '{
    alu: A_NOP, msel: MS_NONE, pp: PP_NONE, fin: FIN_NONE,
    jmp: J_NONE, target: '0, last: 1'b0
  };

  function automatic logic [VAL_W-1:0] mag48(input logic signed [VAL_W-1:0] v);
    logic [VAL_W-1:0] r;
    r = v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
    return r;
  endfunction

  function automatic logic signed [SUM_W-1:0] ext51(input logic signed [VAL_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    r = {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] sat48(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    logic signed [VAL_W-1:0] r;
    hi = 51'sd140737488355327;
    lo = -51'sd140737488355328;
    if (v > hi) begin
      r = hi[VAL_W-1:0];
    end else if (v < lo) begin
      r = lo[VAL_W-1:0];
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/adrc_seq.sv
// Microcode sequencer: step counter, control store and jump logic.
// Depends on adrc_pkg for the control word layout.
module adrc_seq import adrc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     seeded,
  input  logic     out_hold,
  output logic     busy,
  output logic     emit,
  output uc_word_t ctl
);

  logic [UC_PC_W-1:0] pc;
  uc_word_t word;

  function automatic uc_word_t uc_rom(input logic [UC_PC_W-1:0] addr);
    uc_word_t w;
    w = UC_NOP;
    case (addr)
      6'd0:  w.alu = A_ERR;
      6'd1:  begin w.jmp = J_SEEDED; w.target = 6'd3; end
      6'd2:  w.alu = A_SEED;
      6'd3:  w.alu = A_D;
      6'd4:  w.msel = MS_B1D;
      6'd5:  w.pp = PP_LL;
      6'd6:  w.pp = PP_HL;
      6'd7:  w.pp = PP_LH;
      6'd8:  w.pp = PP_HH;
      6'd9:  begin w.fin = FIN_Q16; w.msel = MS_B2D; end
      6'd10: begin w.alu = A_N1; w.pp = PP_LL; end
      6'd11: w.pp = PP_HL;
      6'd12: w.pp = PP_LH;
      6'd13: w.pp = PP_HH;
      6'd14: begin w.fin = FIN_Q16; w.msel = MS_B0P; end
      6'd15: begin w.alu = A_N2A; w.pp = PP_LL; end
      6'd16: w.pp = PP_HL;
      6'd17: w.pp = PP_LH;
      6'd18: w.pp = PP_HH;
      6'd19: begin w.fin = FIN_Q16; w.msel = MS_B3D; end
      6'd20: begin w.alu = A_N2B; w.pp = PP_LL; end
      6'd21: w.pp = PP_HL;
      6'd22: w.pp = PP_LH;
      6'd23: w.pp = PP_HH;
      6'd24: begin w.fin = FIN_Q16; w.msel = MS_DT1; end
      6'd25: begin w.alu = A_N3; w.pp = PP_LL; end
      6'd26: w.pp = PP_LH;
      6'd27: begin w.fin = FIN_Q24; w.msel = MS_DT2; end
      6'd28: begin w.alu = A_Z1; w.pp = PP_LL; end
      6'd29: w.pp = PP_LH;
      6'd30: begin w.fin = FIN_Q24; w.msel = MS_DT3; end
      6'd31: begin w.alu = A_Z2; w.pp = PP_LL; end
      6'd32: w.pp = PP_LH;
      6'd33: begin w.fin = FIN_Q24; w.msel = MS_KPZ1; end
      6'd34: begin w.alu = A_Z3; w.pp = PP_LL; end
      6'd35: w.pp = PP_HL;
      6'd36: w.pp = PP_LH;
      6'd37: w.pp = PP_HH;
      6'd38: begin w.fin = FIN_Q16; w.msel = MS_KDZ2; end
      6'd39: begin w.alu = A_T1; w.pp = PP_LL; end
      6'd40: w.pp = PP_HL;
      6'd41: w.pp = PP_LH;
      6'd42: w.pp = PP_HH;
      6'd43: begin w.fin = FIN_Q16; w.msel = MS_KZZ3; end
      6'd44: begin w.alu = A_T2; w.pp = PP_LL; end
      6'd45: w.pp = PP_HL;
      6'd46: w.pp = PP_LH;
      6'd47: w.pp = PP_HH;
      6'd48: w.fin = FIN_Q16;
      6'd49: w.alu = A_T3;
      6'd50: w.alu = A_CLAMP;
      6'd51: w.last = 1'b1;
      default: w = UC_NOP;
    endcase
    return w;
  endfunction

  assign word = uc_rom(pc);
  assign ctl = busy ? word : UC_NOP;
  assign emit = busy && word.last && !out_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc <= '0;
    end else if (start) begin
      busy <= 1'b1;
      pc <= '0;
    end else if (busy) begin
      if (word.last) begin
        if (!out_hold) begin
          busy <= 1'b0;
        end
      end else if (word.jmp == J_SEEDED && seeded) begin
        pc <= word.target;
      end else begin
        pc <= pc + 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/adrc_mul.sv
// Sign-magnitude multiplier built from one 24x24 partial product per cycle.
// Rounds toward zero after a 16 or 24 bit shift and saturates; uses adrc_pkg.
module adrc_mul import adrc_pkg::*; (
  input  logic                    clk,
  input  logic                    load,
  input  logic signed [VAL_W-1:0] a,
  input  logic signed [VAL_W-1:0] b,
  input  pp_t                     pp,
  input  fin_t                    fin,
  output logic signed [VAL_W-1:0] p
);

  logic [VAL_W-1:0] ua;
  logic [VAL_W-1:0] ub;
  logic neg;
  logic [2*VAL_W-1:0] acc;
  logic [DT_W-1:0] x;
  logic [DT_W-1:0] y;
  logic [VAL_W-1:0] prod;
  logic [2*VAL_W-1:0] addend;
  logic [79:0] m_full;
  logic [VAL_W-1:0] lim;
  logic [VAL_W-1:0] m;

  always_comb begin
    x = '0;
    y = '0;
    unique case (pp)
      PP_LL: begin x = ua[23:0]; y = ub[23:0]; end
      PP_HL: begin x = ua[47:24]; y = ub[23:0]; end
      PP_LH: begin x = ua[23:0]; y = ub[47:24]; end
      PP_HH: begin x = ua[47:24]; y = ub[47:24]; end
      default: begin x = '0; y = '0; end
    endcase
  end

  assign prod = x * y;

  always_comb begin
    unique case (pp)
      PP_LL: addend = {48'd0, prod};
      PP_HL, PP_LH: addend = {24'd0, prod, 24'd0};
      PP_HH: addend = {prod, 48'd0};
      default: addend = '0;
    endcase
  end

  always_comb begin
    m_full = (fin == FIN_Q24) ? {8'd0, acc[95:24]} : acc[95:16];
    lim = neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    m = (m_full > {32'd0, lim}) ? lim : m_full[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ua <= mag48(a);
      ub <= mag48(b);
      neg <= a[VAL_W-1] ^ b[VAL_W-1];
      acc <= '0;
    end else if (pp != PP_NONE) begin
      acc <= acc + addend;
    end
    if (fin != FIN_NONE) begin
      p <= neg ? VAL_W'(-m) : m;
    end
  end

endmodule

>>> rtl/core/adrc_dp.sv
// Datapath: configuration registers, observer state, saturating adder and
// operand selection for the shared multiplier. Uses adrc_pkg and adrc_mul.
module adrc_dp import adrc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  uc_word_t                ctl,
  input  logic                    accept,
  input  logic                    emit,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic signed [VAL_W-1:0] cfg_data,
  input  logic signed [VAL_W-1:0] measured_value,
  input  logic signed [VAL_W-1:0] setpoint,
  input  logic [DT_W-1:0]         time_step,
  input  logic                    restart,
  output logic                    seeded,
  output logic signed [VAL_W-1:0] trim_out,
  output logic signed [VAL_W-1:0] error_out,
  output logic signed [VAL_W-1:0] position_estimate_out,
  output logic signed [VAL_W-1:0] rate_estimate_out,
  output logic signed [VAL_W-1:0] disturbance_estimate_out
);

  logic signed [VAL_W-1:0] input_gain;
  logic signed [VAL_W-1:0] beta1;
  logic signed [VAL_W-1:0] beta2;
  logic signed [VAL_W-1:0] beta3;
  logic signed [VAL_W-1:0] kp;
  logic signed [VAL_W-1:0] kd;
  logic signed [VAL_W-1:0] kz;
  logic signed [VAL_W-1:0] out_limit;

  logic signed [VAL_W-1:0] z1;
  logic signed [VAL_W-1:0] z2;
  logic signed [VAL_W-1:0] z3;
  logic signed [VAL_W-1:0] prev;

  logic signed [VAL_W-1:0] meas;
  logic signed [VAL_W-1:0] target;
  logic [DT_W-1:0] dt;
  logic signed [VAL_W-1:0] e;
  logic signed [VAL_W-1:0] d;
  logic signed [VAL_W-1:0] n1;
  logic signed [VAL_W-1:0] n2;
  logic signed [VAL_W-1:0] n3;
  logic signed [SUM_W-1:0] t;

  logic signed [VAL_W-1:0] b0;
  logic signed [VAL_W-1:0] dt_s;
  logic signed [VAL_W-1:0] ma;
  logic signed [VAL_W-1:0] mb;
  logic signed [VAL_W-1:0] p;
  logic signed [SUM_W-1:0] x;
  logic signed [SUM_W-1:0] y;
  logic signed [SUM_W-1:0] sum;
  logic signed [VAL_W-1:0] sat_sum;
  logic signed [VAL_W+1:0] lim;
  logic signed [VAL_W+1:0] trim_w;
  logic signed [VAL_W-1:0] trim;

  assign b0 = (mag48(input_gain) < B0_FLOOR) ? $signed(B0_FLOOR) : input_gain;
  assign dt_s = $signed({{(VAL_W-DT_W){1'b0}}, dt});

  always_comb begin
    unique case (ctl.msel)
      MS_B1D:  begin ma = beta1; mb = d; end
      MS_B2D:  begin ma = beta2; mb = d; end
      MS_B0P:  begin ma = b0; mb = prev; end
      MS_B3D:  begin ma = beta3; mb = d; end
      MS_DT1:  begin ma = dt_s; mb = n1; end
      MS_DT2:  begin ma = dt_s; mb = n2; end
      MS_DT3:  begin ma = dt_s; mb = n3; end
      MS_KPZ1: begin ma = kp; mb = z1; end
      MS_KDZ2: begin ma = kd; mb = z2; end
      MS_KZZ3: begin ma = kz; mb = z3; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  adrc_mul u_mul (
    .clk  (clk),
    .load (ctl.msel != MS_NONE),
    .a    (ma),
    .b    (mb),
    .pp   (ctl.pp),
    .fin  (ctl.fin),
    .p    (p)
  );

  always_comb begin
    unique case (ctl.alu)
      A_ERR:   begin x = ext51(meas); y = -ext51(target); end
      A_D:     begin x = ext51(z1); y = -ext51(e); end
      A_N1:    begin x = ext51(z2); y = -ext51(p); end
      A_N2A:   begin x = ext51(z3); y = -ext51(p); end
      A_N2B:   begin x = t; y = ext51(p); end
      A_N3:    begin x = '0; y = -ext51(p); end
      A_Z1:    begin x = ext51(z1); y = ext51(p); end
      A_Z2:    begin x = ext51(z2); y = ext51(p); end
      A_Z3:    begin x = ext51(z3); y = ext51(p); end
      A_T1:    begin x = '0; y = ext51(p); end
      A_T2, A_T3: begin x = t; y = ext51(p); end
      A_CLAMP: begin x = t; y = '0; end
      default: begin x = '0; y = '0; end
    endcase
  end

  assign sum = x + y;
  assign sat_sum = sat48(sum);

  always_comb begin
    lim = $signed({2'b00, mag48(out_limit)});
    trim_w = {{2{sat_sum[VAL_W-1]}}, sat_sum};
    if (trim_w > lim) begin
      trim = lim[VAL_W-1:0];
    end else if (trim_w < -lim) begin
      trim = VAL_W'(-lim);
    end else begin
      trim = sat_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      input_gain <= GAIN_RESET;
      beta1 <= '0;
      beta2 <= '0;
      beta3 <= '0;
      kp <= '0;
      kd <= '0;
      kz <= '0;
      out_limit <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_INPUT_GAIN: input_gain <= cfg_data;
        REG_BETA1:      beta1 <= cfg_data;
        REG_BETA2:      beta2 <= cfg_data;
        REG_BETA3:      beta3 <= cfg_data;
        REG_KP:         kp <= cfg_data;
        REG_KD:         kd <= cfg_data;
        REG_KZ:         kz <= cfg_data;
        REG_LIMIT:      out_limit <= cfg_data;
        default:        out_limit <= out_limit;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      z1 <= '0;
      z2 <= '0;
      z3 <= '0;
      prev <= '0;
      seeded <= 1'b0;
    end else begin
      if (accept && restart) begin
        seeded <= 1'b0;
      end
      unique case (ctl.alu)
        A_SEED: begin
          z1 <= e;
          z2 <= '0;
          z3 <= '0;
          prev <= '0;
          seeded <= 1'b1;
        end
        A_Z1:    z1 <= sat_sum;
        A_Z2:    z2 <= sat_sum;
        A_Z3:    z3 <= sat_sum;
        A_CLAMP: prev <= trim;
        default: prev <= prev;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      meas <= measured_value;
      target <= setpoint;
      dt <= (time_step == '0) ? DEFAULT_DT : time_step;
    end
    unique case (ctl.alu)
      A_ERR:   e <= sat_sum;
      A_D:     d <= sat_sum;
      A_N1:    n1 <= sat_sum;
      A_N2B:   n2 <= sat_sum;
      A_N3:    n3 <= sat_sum;
      A_N2A, A_T1, A_T2, A_T3: t <= sum;
      default: t <= t;
    endcase
    if (emit) begin
      trim_out <= prev;
      error_out <= e;
      position_estimate_out <= z1;
      rate_estimate_out <= z2;
      disturbance_estimate_out <= z3;
    end
  end

endmodule

>>> rtl/core/adrc_linear_eso_step.sv
// Linear ADRC step with a third-order extended state observer.
// Takes one request at a time: in_ready stays low until its result is emitted,
// which waits while an earlier result is held by out_ready low. The shared 24x24
// multiplier does 34 partial products under the microcode program.
// Reset clears the observer state and the seeded flag, and returns the config
// registers to their defaults (input gain 1.0, all others zero).
module adrc_linear_eso_step import adrc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [VAL_W-1:0] measured_value,
  input  logic signed [VAL_W-1:0] setpoint,
  input  logic [DT_W-1:0]         time_step,
  input  logic                    restart,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] trim_out,
  output logic signed [VAL_W-1:0] error_out,
  output logic signed [VAL_W-1:0] position_estimate_out,
  output logic signed [VAL_W-1:0] rate_estimate_out,
  output logic signed [VAL_W-1:0] disturbance_estimate_out,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic signed [VAL_W-1:0] cfg_data
);

  logic busy;
  logic emit;
  logic accept;
  logic seeded;
  logic out_hold;
  uc_word_t ctl;

  assign in_ready = !busy;
  assign accept = in_valid && in_ready;
  assign out_hold = out_valid && !out_ready;

  adrc_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .seeded   (seeded),
    .out_hold (out_hold),
    .busy     (busy),
    .emit     (emit),
    .ctl      (ctl)
  );

  adrc_dp u_dp (
    .clk                      (clk),
    .rst                      (rst),
    .ctl                      (ctl),
    .accept                   (accept),
    .emit                     (emit),
    .cfg_write                (cfg_write),
    .cfg_index                (cfg_index),
    .cfg_data                 (cfg_data),
    .measured_value           (measured_value),
    .setpoint                 (setpoint),
    .time_step                (time_step),
    .restart                  (restart),
    .seeded                   (seeded),
    .trim_out                 (trim_out),
    .error_out                (error_out),
    .position_estimate_out    (position_estimate_out),
    .rate_estimate_out        (rate_estimate_out),
    .disturbance_estimate_out (disturbance_estimate_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> tb/tb_adrc_linear_eso_step.sv
// Self-checking testbench for adrc_linear_eso_step: a bit-exact observer predictor,
// a burst/gap request driver, a stalling result monitor and gain banks per phase.
// Depends on adrc_pkg and the adrc_linear_eso_step RTL.
`timescale 1ns / 1ps

module tb_adrc_linear_eso_step;
  import adrc_pkg::*;

  typedef logic signed [VAL_W-1:0] q16_t;
  typedef logic signed [63:0] wide_t;

  typedef struct {
    q16_t measured;
    q16_t target;
    logic [DT_W-1:0] dt;
    logic clear;
  } request_t;

  typedef struct {
    q16_t trim;
    q16_t error;
    q16_t position;
    q16_t rate;
    q16_t disturbance;
  } estimate_t;

  typedef enum {BANK_TUNED, BANK_TINY_GAIN, BANK_TOP, BANK_BOTTOM, BANK_WILD} bank_kind_t;

  localparam q16_t Q16_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam q16_t Q16_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam int NUM_REGS = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  q16_t measured_value = '0;
  q16_t setpoint = '0;
  logic [DT_W-1:0] time_step = '0;
  logic restart = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  q16_t trim_out;
  q16_t error_out;
  q16_t position_estimate_out;
  q16_t rate_estimate_out;
  q16_t disturbance_estimate_out;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  q16_t cfg_data = '0;

  adrc_linear_eso_step u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .measured_value(measured_value),
    .setpoint(setpoint),
    .time_step(time_step),
    .restart(restart),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .trim_out(trim_out),
    .error_out(error_out),
    .position_estimate_out(position_estimate_out),
    .rate_estimate_out(rate_estimate_out),
    .disturbance_estimate_out(disturbance_estimate_out),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Observer shadow state and gain bank
  q16_t gain_reg [NUM_REGS];
  q16_t obs_pos = '0;
  q16_t obs_rate = '0;
  q16_t obs_dist = '0;
  q16_t prior_trim = '0;
  bit obs_seeded = 1'b0;

  request_t request_q[$];
  estimate_t estimate_q[$];
  request_t cur_req;
  int queued_count = 0;
  int accepted_count = 0;
  int checked_count = 0;
  int fault_count = 0;
  int restart_count = 0;
  int default_dt_count = 0;
  int bank_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int rx_left = 0;

  function automatic q16_t clip48(wide_t v);
    if (v > wide_t'(Q16_MAX)) return Q16_MAX;
    if (v < wide_t'(Q16_MIN)) return Q16_MIN;
    return v[VAL_W-1:0];
  endfunction

  // Exact product, truncated toward zero after the shift, saturated to 48 bits
  function automatic wide_t fixed_mul(wide_t a, wide_t b, int frac);
    logic [127:0] ma;
    logic [127:0] mb;
    logic [127:0] prod;
    logic [127:0] lim;
    logic neg;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? 128'(-a) : 128'(a);
    mb = (b < 0) ? 128'(-b) : 128'(b);
    prod = (ma * mb) >> frac;
    lim = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
    if (prod > lim) prod = lim;
    return neg ? -wide_t'(prod[63:0]) : wide_t'(prod[63:0]);
  endfunction

  function automatic estimate_t advance_observer(request_t req);
    wide_t b0;
    wide_t dtw;
    wide_t e;
    wide_t d;
    wide_t n1;
    wide_t n2;
    wide_t n3;
    wide_t t;
    wide_t lim;
    estimate_t r;
    if (req.clear) obs_seeded = 1'b0;
    dtw = (req.dt == '0) ? {40'd0, DEFAULT_DT} : {40'd0, req.dt};
    b0 = gain_reg[REG_INPUT_GAIN];
    if ((b0 < 0 ? -b0 : b0) < {16'd0, B0_FLOOR}) b0 = {16'd0, B0_FLOOR};
    e = clip48(wide_t'(req.measured) - wide_t'(req.target));
    if (!obs_seeded) begin
      obs_pos = e[VAL_W-1:0];
      obs_rate = '0;
      obs_dist = '0;
      prior_trim = '0;
      obs_seeded = 1'b1;
    end
    d = clip48(wide_t'(obs_pos) - e);
    n1 = clip48(wide_t'(obs_rate) - fixed_mul(gain_reg[REG_BETA1], d, 16));
    n2 = clip48(wide_t'(obs_dist) - fixed_mul(gain_reg[REG_BETA2], d, 16)
                + fixed_mul(b0, prior_trim, 16));
    n3 = clip48(-fixed_mul(gain_reg[REG_BETA3], d, 16));
    obs_pos = clip48(wide_t'(obs_pos) + fixed_mul(dtw, n1, 24));
    obs_rate = clip48(wide_t'(obs_rate) + fixed_mul(dtw, n2, 24));
    obs_dist = clip48(wide_t'(obs_dist) + fixed_mul(dtw, n3, 24));
    t = clip48(fixed_mul(gain_reg[REG_KP], obs_pos, 16)
               + fixed_mul(gain_reg[REG_KD], obs_rate, 16)
               + fixed_mul(gain_reg[REG_KZ], obs_dist, 16));
    lim = gain_reg[REG_LIMIT];
    if (lim < 0) lim = -lim;
    if (t > lim) t = lim;
    if (t < -lim) t = -lim;
    prior_trim = t[VAL_W-1:0];
    r.trim = prior_trim;
    r.error = e[VAL_W-1:0];
    r.position = obs_pos;
    r.rate = obs_rate;
    r.disturbance = obs_dist;
    return r;
  endfunction

  function automatic q16_t spread(int unsigned span);
    return q16_t'(wide_t'($urandom_range(0, 2 * span)) - wide_t'(span));
  endfunction

  function automatic q16_t pick_value();
    wide_t w;
    w = $signed({$urandom, $urandom});
    case ($urandom_range(0, 9))
      0: return Q16_MAX;
      1: return Q16_MIN;
      2: return '0;
      3, 4, 5: return spread(1 << 24);
      6, 7, 8: return q16_t'(w >>> 27);
      default: return q16_t'(w);
    endcase
  endfunction

  function automatic logic [DT_W-1:0] pick_step();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return DEFAULT_DT;
      2: return '1;
      3: return DT_W'($urandom_range(1, 1000));
      default: return DT_W'($urandom);
    endcase
  endfunction

  task automatic queue_request(q16_t m, q16_t s, logic [DT_W-1:0] dt, logic clr);
    request_t req;
    req.measured = m;
    req.target = s;
    req.dt = dt;
    req.clear = clr;
    request_q.push_back(req);
    queued_count++;
    if (clr) restart_count++;
    if (dt == '0) default_dt_count++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (accepted_count != queued_count || estimate_q.size() != 0);
  endtask

  task automatic write_reg(int idx, q16_t value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data <= value;
    gain_reg[idx] = value;
  endtask

  task automatic program_bank(bank_kind_t kind);
    q16_t bank [NUM_REGS];
    wide_t w0;
    int idx;
    w0 = $urandom_range(2, 40);
    bank[REG_INPUT_GAIN] = q16_t'($urandom_range(6554, 655360));
    bank[REG_BETA1] = q16_t'((3 * w0) <<< 16);
    bank[REG_BETA2] = q16_t'((3 * w0 * w0) <<< 16);
    bank[REG_BETA3] = q16_t'((w0 * w0 * w0) <<< 16);
    bank[REG_KP] = spread(100 << 16);
    bank[REG_KD] = spread(20 << 16);
    bank[REG_KZ] = spread(2 << 16);
    bank[REG_LIMIT] = spread(1000 << 16);
    case (kind)
      BANK_TINY_GAIN: bank[REG_INPUT_GAIN] = spread(66);
      BANK_TOP: begin
        foreach (bank[i]) bank[i] = Q16_MAX;
        bank[REG_LIMIT] = Q16_MIN;
      end
      BANK_BOTTOM: begin
        foreach (bank[i]) bank[i] = Q16_MIN;
        bank[REG_LIMIT] = -48'sd65536000;
      end
      BANK_WILD: foreach (bank[i]) bank[i] = pick_value();
      default: ;
    endcase
    for (idx = 0; idx < NUM_REGS; idx++) write_reg(idx, bank[idx]);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
    bank_count++;
  endtask

  // Mostly settling tracks toward a target, with some noise requests mixed in
  task automatic queue_random(int count);
    int left;
    int run_len;
    int i;
    q16_t target;
    q16_t meas;
    logic [DT_W-1:0] dt;
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 4) == 0) begin
        queue_request(pick_value(), pick_value(), pick_step(), $urandom_range(0, 7) == 0);
        left--;
      end else begin
        run_len = $urandom_range(4, 40);
        target = spread(1 << 26);
        meas = target + spread(1 << 21);
        case ($urandom_range(0, 2))
          0: dt = '0;
          1: dt = DEFAULT_DT;
          default: dt = DT_W'($urandom_range(1000, 100000));
        endcase
        for (i = 0; i < run_len && left > 0; i++) begin
          queue_request(meas, target, dt, i == 0 && $urandom_range(0, 2) == 0);
          meas = meas + ((target - meas) >>> 3) + spread(1 << 16);
          left--;
        end
      end
    end
  endtask

  task automatic check_field(string field, q16_t want, q16_t got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      fault_count++;
    end
  endtask

  // Request driver: bursts of random length, random gaps between them
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        estimate_q.push_back(advance_observer(cur_req));
        accepted_count++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          cur_req = request_q.pop_front();
          measured_value <= cur_req.measured;
          setpoint <= cur_req.target;
          time_step <= cur_req.dt;
          restart <= cur_req.clear;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with its own stall pattern
  always @(posedge clk) begin : monitor
    estimate_t want;
    if (rst) begin
      out_ready <= 1'b0;
      rx_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (estimate_q.size() == 0) begin
          $error("result with no request outstanding: trim %0d", trim_out);
          fault_count++;
        end else begin
          want = estimate_q.pop_front();
          check_field("trim_out", want.trim, trim_out);
          check_field("error_out", want.error, error_out);
          check_field("position_estimate_out", want.position, position_estimate_out);
          check_field("rate_estimate_out", want.rate, rate_estimate_out);
          check_field("disturbance_estimate_out", want.disturbance,
                      disturbance_estimate_out);
          checked_count++;
        end
      end
      if (rx_left == 0) begin
        if (out_ready && $urandom_range(0, 3) != 0) begin
          out_ready <= 1'b0;
          rx_left = $urandom_range(1, 40);
        end else begin
          out_ready <= 1'b1;
          rx_left = $urandom_range(1, 120);
        end
      end else begin
        rx_left--;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    bank_kind_t plan [8];
    int ph;
    foreach (gain_reg[i]) gain_reg[i] = '0;
    gain_reg[REG_INPUT_GAIN] = GAIN_RESET;
    plan = '{BANK_TUNED, BANK_TINY_GAIN, BANK_WILD, BANK_TUNED,
             BANK_TOP, BANK_BOTTOM, BANK_TINY_GAIN, BANK_WILD};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset gains: first request seeds, error saturation both ways
    queue_request('0, '0, '0, 1'b0);
    queue_request(Q16_MAX, Q16_MIN, '1, 1'b0);
    queue_request(Q16_MIN, Q16_MAX, DT_W'(1), 1'b0);
    queue_request(48'sd6553600, '0, '0, 1'b1);
    queue_request(-48'sd1, 48'sd1, DEFAULT_DT, 1'b0);
    wait_drained();

    program_bank(BANK_TUNED);
    queue_request(48'sd655360, '0, DEFAULT_DT, 1'b1);
    queue_request(48'sd600000, '0, DEFAULT_DT, 1'b0);
    queue_request(48'sd500000, '0, '0, 1'b0);
    queue_request(48'sd300000, '0, '0, 1'b0);
    queue_request(48'sd100000, '0, DEFAULT_DT, 1'b0);
    queue_request(-48'sd20000, '0, DEFAULT_DT, 1'b0);
    queue_request('0, '0, '1, 1'b0);
    wait_drained();

    program_bank(BANK_TOP);
    queue_request(Q16_MAX, '0, '1, 1'b1);
    queue_request(Q16_MIN, '0, '1, 1'b0);
    queue_request('0, Q16_MAX, DT_W'(1), 1'b0);
    queue_request(48'sd1, '0, '0, 1'b0);
    queue_request(Q16_MIN, Q16_MIN, '1, 1'b0);
    wait_drained();

    program_bank(BANK_BOTTOM);
    queue_request(Q16_MIN, Q16_MAX, '1, 1'b1);
    queue_request(Q16_MAX, '0, '1, 1'b0);
    queue_request('0, '0, '0, 1'b0);
    queue_request(48'sd65536, '0, DEFAULT_DT, 1'b0);
    wait_drained();

    program_bank(BANK_TINY_GAIN);
    queue_request(48'sd6553600, '0, DEFAULT_DT, 1'b1);
    queue_request(48'sd3276800, '0, DEFAULT_DT, 1'b0);
    queue_request(48'sd1638400, '0, '0, 1'b0);
    wait_drained();

    // hold the sender at each bank change until every result is back
    for (ph = 0; ph < 8; ph++) begin
      program_bank(plan[ph]);
      queue_random(200);
      wait_drained();
    end

    repeat (60) @(posedge clk);
    $display("Checked %0d of %0d requests across %0d gain banks", checked_count,
             accepted_count, bank_count);
    $display("Included %0d restarts and %0d zero time steps", restart_count,
             default_dt_count);
    if (fault_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/adrc_pkg.sv
rtl/core/adrc_seq.sv
rtl/core/adrc_mul.sv
rtl/core/adrc_dp.sv
rtl/core/adrc_linear_eso_step.sv
tb/tb_adrc_linear_eso_step.sv
